// File: design/lsdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdp_pkg
// Shared types and constants of the looping sample DAC player: item codes,
// register indexes, reset values and the status carried down the pipeline.
// ----------------------------------------------------------------------------
package lsdp_pkg;

	// Field widths
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int STEP_W   = 15;
	localparam int RATE_W   = 22;
	localparam int POS_W    = 17;
	localparam int PHASE_W  = 23;
	localparam int DAC_W    = 8;
	localparam int CIDX_W   = 3;
	localparam int CDATA_W  = 22;

	// Default sample store depth (power of two)
	localparam int SAMPLE_DEPTH_DEF = 65536;

	// Reset and arithmetic constants
	localparam logic [RATE_W-1:0]  OUT_RATE_RST = 22'd1789773;
	localparam logic [PHASE_W-1:0] PHASE_MAX    = 23'h7FFFFF;
	localparam logic [BYTE_W-1:0]  SIGN_FLIP    = 8'h80;
	localparam logic [DAC_W-1:0]   RAMP_STEP    = 8'd8;

	// Item codes
	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// Register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_OUT_RATE  = 3'd0,
		REG_SAMPLE_LEN = 3'd1,
		REG_LOOP_EN   = 3'd2,
		REG_LOOP_START = 3'd3,
		REG_LOOP_END  = 3'd4,
		REG_MUTE      = 3'd5,
		REG_DPCM      = 3'd6
	} reg_idx_t;

	// Status of one item, handed from the control stage to the output stage
	typedef struct packed {
		logic wr;       // item writes the DAC
		logic playing;  // active flag after the item
	} item_res_t;

endpackage

// File: design/looping_sample_dac_player_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_sample_dac_player_unit
// Looping sample player with a fractional-rate phase accumulator feeding an
// 8-bit DAC, with an anti-click ramp after reset.
// ----------------------------------------------------------------------------
// One item is taken per clock while in_ready is high, and every item gives
// exactly one result via the read and result registers. The rate is set by
// the control stage, which updates accumulator and play position in the cycle
// an item is taken while the sample store reads the current position; the
// read data and the ramp meet one stage later. SAMPLE_DEPTH must be a power
// of two; load addresses and play positions wrap modulo the depth. No
// clearing pass: an entry must be loaded before playback reaches it.
module looping_sample_dac_player_unit #(
	parameter int SAMPLE_DEPTH = lsdp_pkg::SAMPLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lsdp_pkg::OP_W-1:0]     op,
	input  logic [lsdp_pkg::ADDR_W-1:0]   mem_addr,
	input  logic signed [lsdp_pkg::BYTE_W-1:0] sample_byte,
	input  logic [lsdp_pkg::STEP_W-1:0]   step_rate,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          dac_write,
	output logic [lsdp_pkg::DAC_W-1:0]    dac_value,
	output logic                          playing,
	input  logic                          cfg_we,
	input  logic [lsdp_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [lsdp_pkg::CDATA_W-1:0]  cfg_data
);

	localparam int AW  = $clog2(SAMPLE_DEPTH);
	localparam int XAW = (AW > lsdp_pkg::ADDR_W) ? AW : lsdp_pkg::ADDR_W;
	localparam int XPW = (AW > lsdp_pkg::POS_W) ? AW : lsdp_pkg::POS_W;

	logic                         acc;
	logic                         load;
	logic [lsdp_pkg::POS_W-1:0]   pos;
	lsdp_pkg::item_res_t          res;
	logic [AW-1:0]                waddr;
	logic [AW-1:0]                raddr;
	logic [lsdp_pkg::BYTE_W-1:0]  rdata;

	assign acc   = in_valid && in_ready;
	assign load  = acc && (lsdp_pkg::op_t'(op) == lsdp_pkg::OP_LOAD);
	// Wrap addresses to the store depth
	assign waddr = AW'(XAW'(mem_addr));
	assign raddr = AW'(XPW'(pos));

	lsdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.op        (op),
		.step_rate (step_rate),
		.pos       (pos),
		.res       (res)
	);

	lsdp_mem #(
		.AW (AW)
	) u_mem (
		.clk   (clk),
		.we    (load),
		.waddr (waddr),
		.wdata (sample_byte),
		.re    (acc),
		.raddr (raddr),
		.rdata (rdata)
	);

	lsdp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.res       (res),
		.rdata     (rdata),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dac_write (dac_write),
		.dac_value (dac_value),
		.playing   (playing)
	);

endmodule

// File: design/lsdp_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdp_mem
// Sample store: one write port, one read port with registered read data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module lsdp_mem #(
	parameter int AW = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [lsdp_pkg::BYTE_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [lsdp_pkg::BYTE_W-1:0] rdata
);

	logic [lsdp_pkg::BYTE_W-1:0] mem_q [2**AW];
	logic [lsdp_pkg::BYTE_W-1:0] rdata_q;

	// Write on load, read on every accepted item
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/lsdp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdp_ctrl
// Configuration registers and playback control: phase accumulator, play
// position, active flag and latched step. Playback state is updated once per accepted item.
// ----------------------------------------------------------------------------
module lsdp_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lsdp_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [lsdp_pkg::CDATA_W-1:0] cfg_data,
	input  logic                         acc,
	input  logic [lsdp_pkg::OP_W-1:0]    op,
	input  logic [lsdp_pkg::STEP_W-1:0]  step_rate,
	output logic [lsdp_pkg::POS_W-1:0]   pos,
	output lsdp_pkg::item_res_t          res
);

	// Configuration
	logic [lsdp_pkg::RATE_W-1:0] out_rate_q;
	logic [lsdp_pkg::POS_W-1:0]  sample_len_q;
	logic                        loop_en_q;
	logic [lsdp_pkg::ADDR_W-1:0] loop_start_q;
	logic [lsdp_pkg::POS_W-1:0]  loop_end_q;
	logic                        mute_q;
	logic                        dpcm_q;

	// Playback state
	logic [lsdp_pkg::PHASE_W-1:0] phase_q;
	logic [lsdp_pkg::POS_W-1:0]   pos_q;
	logic                         active_q;
	logic [lsdp_pkg::STEP_W-1:0]  step_q;

	// Next-state terms
	logic [lsdp_pkg::PHASE_W:0]   sum;
	logic [lsdp_pkg::PHASE_W-1:0] phase_sat;
	logic                         fire;
	logic [lsdp_pkg::POS_W:0]     pos_inc;
	logic [lsdp_pkg::PHASE_W-1:0] phase_d;
	logic [lsdp_pkg::POS_W-1:0]   pos_d;
	logic                         active_d;
	logic                         wr_d;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_rate_q   <= lsdp_pkg::OUT_RATE_RST;
			sample_len_q <= '0;
			loop_en_q    <= 1'b0;
			loop_start_q <= '0;
			loop_end_q   <= '0;
			mute_q       <= 1'b0;
			dpcm_q       <= 1'b0;
		end else if (cfg_we) begin
			case (lsdp_pkg::reg_idx_t'(cfg_index))
				lsdp_pkg::REG_OUT_RATE:   out_rate_q   <= cfg_data[lsdp_pkg::RATE_W-1:0];
				lsdp_pkg::REG_SAMPLE_LEN: sample_len_q <= cfg_data[lsdp_pkg::POS_W-1:0];
				lsdp_pkg::REG_LOOP_EN:    loop_en_q    <= cfg_data[0];
				lsdp_pkg::REG_LOOP_START: loop_start_q <= cfg_data[lsdp_pkg::ADDR_W-1:0];
				lsdp_pkg::REG_LOOP_END:   loop_end_q   <= cfg_data[lsdp_pkg::POS_W-1:0];
				lsdp_pkg::REG_MUTE:       mute_q       <= cfg_data[0];
				lsdp_pkg::REG_DPCM:       dpcm_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Saturating accumulate and threshold compare
	assign sum       = {1'b0, phase_q} + (lsdp_pkg::PHASE_W+1)'(step_q);
	assign phase_sat = sum[lsdp_pkg::PHASE_W] ? lsdp_pkg::PHASE_MAX
	                                          : sum[lsdp_pkg::PHASE_W-1:0];
	assign fire      = phase_sat >= lsdp_pkg::PHASE_W'(out_rate_q);
	assign pos_inc   = {1'b0, pos_q} + (lsdp_pkg::POS_W+1)'(1);

	// Work out the effect of one item
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		active_d = active_q;
		wr_d     = 1'b0;
		case (lsdp_pkg::op_t'(op))
			lsdp_pkg::OP_START: begin
				phase_d  = '0;
				pos_d    = '0;
				active_d = 1'b1;
			end
			lsdp_pkg::OP_STOP: begin
				active_d = 1'b0;
			end
			lsdp_pkg::OP_TICK: begin
				if (!dpcm_q && active_q) begin
					phase_d = phase_sat;
					if (fire) begin
						if (sample_len_q == '0) begin
							active_d = 1'b0;
						end else begin
							wr_d    = !mute_q;
							phase_d = phase_sat - lsdp_pkg::PHASE_W'(out_rate_q);
							pos_d   = pos_inc[lsdp_pkg::POS_W-1:0];
							if (loop_en_q && pos_inc >= {1'b0, loop_end_q}) begin
								pos_d = lsdp_pkg::POS_W'(loop_start_q);
							end else if (pos_inc >= {1'b0, sample_len_q}) begin
								active_d = 1'b0;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Advance state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			pos_q    <= '0;
			active_q <= 1'b0;
			step_q   <= '0;
		end else if (acc) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			active_q <= active_d;
			if (lsdp_pkg::op_t'(op) == lsdp_pkg::OP_START) begin
				step_q <= step_rate;
			end
		end
	end

	assign pos         = pos_q;
	assign res.wr      = wr_d;
	assign res.playing = active_d;

endmodule

// File: design/lsdp_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdp_out
// Output side: one stage that meets the sample read data, the anti-click
// ramp, and the result register towards the consumer.
// ----------------------------------------------------------------------------
module lsdp_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  lsdp_pkg::item_res_t         res,
	input  logic [lsdp_pkg::BYTE_W-1:0] rdata,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        dac_write,
	output logic [lsdp_pkg::DAC_W-1:0]  dac_value,
	output logic                        playing
);

	logic                       valid_s1;
	lsdp_pkg::item_res_t        res_s1;
	logic                       out_valid_q;
	logic                       dac_write_q;
	logic [lsdp_pkg::DAC_W-1:0] dac_value_q;
	logic                       playing_q;
	logic                       ramp_on_q;
	logic [lsdp_pkg::DAC_W-1:0] ramp_level_q;

	logic                       adv;
	logic [lsdp_pkg::DAC_W-1:0] sample_val;
	logic                       ramp_up;
	logic [lsdp_pkg::DAC_W-1:0] ramp_next;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;

	// Offset binary, shifted right one
	assign sample_val = {1'b0, 7'((rdata ^ lsdp_pkg::SIGN_FLIP) >> 1)};
	assign ramp_up    = ramp_on_q && (ramp_level_q < sample_val);
	assign ramp_next  = ramp_level_q + lsdp_pkg::RAMP_STEP;

	// Hold item status until the read data meets it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_s1   <= '0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
			res_s1   <= res;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Result register and ramp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			ramp_on_q    <= 1'b1;
			ramp_level_q <= '0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1 && res_s1.wr) begin
				if (ramp_up) begin
					ramp_level_q <= ramp_next;
				end else begin
					ramp_on_q <= 1'b0;
				end
			end
		end
	end

	// Payload of the result
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			dac_write_q <= res_s1.wr;
			playing_q   <= res_s1.playing;
			if (!res_s1.wr) begin
				dac_value_q <= '0;
			end else if (ramp_up) begin
				dac_value_q <= ramp_next;
			end else begin
				dac_value_q <= sample_val;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign dac_write = dac_write_q;
	assign dac_value = dac_value_q;
	assign playing   = playing_q;

endmodule

// File: design/lsdp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsdp_chk
// Port-level checks on the result channel of the sample player, bound to
// the top level.
// ----------------------------------------------------------------------------
module lsdp_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       dac_write,
	input logic [lsdp_pkg::DAC_W-1:0] dac_value
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dac_value) && $stable(dac_write))
		else $error("stalled result changed");

	// Drop the value when no DAC write happens
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dac_write |-> dac_value == '0)
		else $error("value without DAC write");

	// Keep written values within sample and ramp range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dac_write |-> dac_value <= 8'd135)
		else $error("DAC value out of range");

endmodule

bind looping_sample_dac_player_unit lsdp_chk u_lsdp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.dac_write (dac_write),
	.dac_value (dac_value)
);

// File: tb/tb_looping_sample_dac_player_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_looping_sample_dac_player_unit
// Drives load, start, stop and tick items into the sample player. The bench
// keeps its own copy of the player state and settings and works out the DAC
// result of every accepted item. Each result that comes out is matched
// against the oldest outstanding prediction. Covered: the anti-click ramp
// after reset, every item code, empty sample, DPCM idling, mute, looping
// past the sample length, loops at the top of the address range, zero
// threshold and accumulator saturation. Randomised settings phases follow,
// with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_looping_sample_dac_player_unit;
	import lsdp_pkg::*;

	typedef struct packed {
		logic       wr;
		logic [7:0] value;
		logic       play;
	} dac_result_t;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    in_valid    = 1'b0;
	logic                    in_ready;
	op_t                     op          = OP_LOAD;
	logic [ADDR_W-1:0]       mem_addr    = '0;
	logic signed [BYTE_W-1:0] sample_byte = '0;
	logic [STEP_W-1:0]       step_rate   = '0;
	logic                    out_valid;
	logic                    out_ready   = 1'b0;
	logic                    dac_write;
	logic [DAC_W-1:0]        dac_value;
	logic                    playing;
	logic                    cfg_we      = 1'b0;
	reg_idx_t                cfg_index   = REG_OUT_RATE;
	logic [CDATA_W-1:0]      cfg_data    = '0;

	// Shadow of the settings registers
	logic [RATE_W-1:0]  r_out_rate   = OUT_RATE_RST;
	logic [POS_W-1:0]   r_len        = '0;
	logic               r_loop_en    = 1'b0;
	logic [ADDR_W-1:0]  r_loop_start = '0;
	logic [POS_W-1:0]   r_loop_end   = '0;
	logic               r_mute       = 1'b0;
	logic               r_dpcm       = 1'b0;

	// Shadow of the player state
	logic [7:0]         pcm_store  [0:65535];
	bit                 pcm_loaded [0:65535];
	logic [POS_W-1:0]   cur_pos    = '0;
	logic [PHASE_W-1:0] acc        = '0;
	logic               running    = 1'b0;
	logic               ramp_armed = 1'b1;
	logic [7:0]         ramp_lvl   = '0;
	logic [STEP_W-1:0]  step_lat   = '0;

	dac_result_t dac_results_due [$];
	int unsigned items_sent = 0;
	int unsigned mismatches = 0;
	int unsigned gap_pct    = 29;
	int unsigned stall_pct  = 29;

	looping_sample_dac_player_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.mem_addr   (mem_addr),
		.sample_byte(sample_byte),
		.step_rate  (step_rate),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dac_write  (dac_write),
		.dac_value  (dac_value),
		.playing    (playing),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Advance the shadow state by one item and return the DAC result it gives
	function automatic dac_result_t next_dac_result(op_t o, logic [15:0] a,
			logic [7:0] b, logic [14:0] s);
		dac_result_t r;
		logic [23:0] sum;
		logic [7:0]  lvl;
		logic [17:0] nxt;
		r = '0;
		case (o)
			OP_LOAD: begin
				pcm_store[a]  = b;
				pcm_loaded[a] = 1'b1;
			end
			OP_START: begin
				step_lat = s;
				cur_pos  = '0;
				acc      = '0;
				running  = 1'b1;
			end
			OP_STOP: running = 1'b0;
			default: begin
				if (!r_dpcm && running) begin
					sum = {1'b0, acc} + step_lat;
					acc = (sum > PHASE_MAX) ? PHASE_MAX : sum[PHASE_W-1:0];
					if (acc >= r_out_rate) begin
						if (r_len == '0) begin
							running = 1'b0;
						end else begin
							if (!r_mute) begin
								lvl = (pcm_store[cur_pos[15:0]] ^ SIGN_FLIP) >> 1;
								if (ramp_armed && ramp_lvl < lvl) begin
									ramp_lvl = ramp_lvl + RAMP_STEP;
									r.value  = ramp_lvl;
								end else begin
									ramp_armed = 1'b0;
									r.value    = lvl;
								end
								r.wr = 1'b1;
							end
							// advance, wrap at the loop end or stop at the sample end
							nxt = {1'b0, cur_pos} + 18'd1;
							if (r_loop_en && nxt >= {1'b0, r_loop_end}) begin
								cur_pos = {1'b0, r_loop_start};
							end else begin
								if (nxt >= {1'b0, r_len})
									running = 1'b0;
								cur_pos = nxt[POS_W-1:0];
							end
							acc = acc - r_out_rate;
						end
					end
				end
			end
		endcase
		r.play = running;
		return r;
	endfunction

	// True when the next tick would play a store entry never loaded
	function automatic bit tick_reads_unloaded();
		logic [23:0] sum;
		sum = {1'b0, acc} + step_lat;
		if (sum > PHASE_MAX)
			sum = PHASE_MAX;
		return !r_dpcm && running && sum >= r_out_rate && r_len != '0
			&& !pcm_loaded[cur_pos[15:0]];
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Match each result transfer against the oldest prediction
	always @(posedge clk) begin : result_check
		dac_result_t due;
		if (arst_n && out_valid && out_ready) begin
			if (dac_results_due.size() == 0) begin
				mismatches++;
				$display("%0t: result expected none, actual write %0d value %0d playing %0d",
					$time, dac_write, dac_value, playing);
			end else begin
				due = dac_results_due.pop_front();
				check_field("dac_write", 8'(due.wr), 8'(dac_write));
				check_field("dac_value", due.value, dac_value);
				check_field("playing", 8'(due.play), 8'(playing));
			end
		end
	end

	// Offer one item, sometimes after a random gap, and hold it until transferred
	task automatic send_item(op_t o, logic [15:0] a, logic [7:0] b, logic [14:0] s);
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
		dac_results_due.push_back(next_dac_result(o, a, b, s));
		in_valid    <= 1'b1;
		op          <= o;
		mem_addr    <= a;
		sample_byte <= b;
		step_rate   <= s;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Tick with random filler fields; load the entry first if it is unloaded
	task automatic send_tick();
		if (tick_reads_unloaded())
			send_item(OP_LOAD, cur_pos[15:0], 8'($urandom), 15'($urandom_range(0, 32000)));
		send_item(OP_TICK, 16'($urandom), 8'($urandom), 15'($urandom_range(0, 32000)));
	endtask

	// Hold off the sender until every predicted result has arrived
	task automatic drain();
		in_valid <= 1'b0;
		while (dac_results_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_reg(reg_idx_t idx, logic [CDATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_OUT_RATE:   r_out_rate   = val;
			REG_SAMPLE_LEN: r_len        = val[POS_W-1:0];
			REG_LOOP_EN:    r_loop_en    = val[0];
			REG_LOOP_START: r_loop_start = val[ADDR_W-1:0];
			REG_LOOP_END:   r_loop_end   = val[POS_W-1:0];
			REG_MUTE:       r_mute       = val[0];
			REG_DPCM:       r_dpcm       = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_player(logic [21:0] rate, logic [16:0] len, logic lp_en,
			logic [15:0] lp_start, logic [16:0] lp_end, logic mute_on, logic dpcm_on);
		set_reg(REG_OUT_RATE, rate);
		set_reg(REG_SAMPLE_LEN, 22'(len));
		set_reg(REG_LOOP_EN, 22'(lp_en));
		set_reg(REG_LOOP_START, 22'(lp_start));
		set_reg(REG_LOOP_END, 22'(lp_end));
		set_reg(REG_MUTE, 22'(mute_on));
		set_reg(REG_DPCM, 22'(dpcm_on));
	endtask

	function automatic logic [14:0] pick_step();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 15'd32000;
			default: return 15'($urandom_range(1, 32000));
		endcase
	endfunction

	// Ramp climbs from zero to 128 on a full-scale sample of 127, then settles on it
	task automatic test_ramp();
		drain();
		program_player(22'd1, 17'd1, 1'b1, 16'd0, 17'd1, 1'b0, 1'b0);
		send_item(OP_LOAD, 16'h0000, 8'h7F, 15'd0);
		send_item(OP_START, 16'h0000, 8'h00, 15'd1);
		repeat (18) send_tick();
	endtask

	// Address and byte extremes, stop, empty sample, DPCM idling and mute
	task automatic test_controls();
		drain();
		program_player(22'd3, 17'd2, 1'b0, 16'd0, 17'd0, 1'b0, 1'b0);
		send_item(OP_LOAD, 16'hFFFF, 8'h80, 15'd32000);
		send_item(OP_LOAD, 16'h0001, 8'h00, 15'd0);
		send_item(OP_START, 16'h0000, 8'h00, 15'd32000);
		repeat (3) send_tick();
		send_item(OP_STOP, 16'h0000, 8'h00, 15'd0);
		send_item(OP_START, 16'h0000, 8'h00, 15'd0);
		send_tick();
		send_item(OP_STOP, 16'h0000, 8'h00, 15'd0);
		// empty sample stops on the first firing tick
		drain();
		set_reg(REG_SAMPLE_LEN, 22'd0);
		send_item(OP_START, 16'h0000, 8'h00, 15'd5);
		send_tick();
		// start still latches in DPCM mode, ticks do nothing
		drain();
		set_reg(REG_DPCM, 22'd1);
		send_item(OP_START, 16'h0000, 8'h00, 15'd7);
		send_tick();
		// muted playback advances without writing
		drain();
		set_reg(REG_DPCM, 22'd0);
		set_reg(REG_MUTE, 22'd1);
		set_reg(REG_SAMPLE_LEN, 22'd2);
		repeat (2) send_tick();
		drain();
		set_reg(REG_MUTE, 22'd0);
	endtask

	// Loops at the top of the address range and past the sample length
	task automatic test_loop_wrap();
		drain();
		program_player(22'd2, 17'd65536, 1'b1, 16'hFFFF, 17'd1, 1'b0, 1'b0);
		send_item(OP_LOAD, 16'hFFFF, 8'h64, 15'd0);
		send_item(OP_START, 16'h0000, 8'h00, 15'd2);
		repeat (2) send_tick();
		drain();
		set_reg(REG_LOOP_END, 22'd65536);
		send_tick();
		drain();
		program_player(22'd2, 17'd1, 1'b1, 16'd0, 17'd3, 1'b0, 1'b0);
		send_item(OP_START, 16'h0000, 8'h00, 15'd2);
		repeat (4) send_tick();
	endtask

	// Zero threshold lets the accumulator climb into saturation
	task automatic test_accum_saturation();
		drain();
		program_player(22'd0, 17'd4, 1'b1, 16'd0, 17'd4, 1'b0, 1'b0);
		send_item(OP_START, 16'($urandom), 8'($urandom), 15'd32000);
		repeat (300) send_tick();
		drain();
		set_reg(REG_OUT_RATE, 22'h3FFFFF);
		repeat (4) send_tick();
	endtask

	// Random settings phases; each starts playback and mostly ticks
	task automatic test_random();
		int unsigned stop_at;
		int unsigned phase_no;
		int unsigned n;
		int unsigned k;
		logic [21:0] rate;
		logic [16:0] len;
		logic [16:0] lend;
		logic [15:0] lstart;
		bit          paused;
		stop_at  = items_sent + 560;
		phase_no = 0;
		paused   = 1'b0;
		while (items_sent < stop_at) begin
			drain();
			gap_pct   = (phase_no == 3) ? 0 : 29;
			stall_pct = gap_pct;
			case ($urandom_range(0, 7))
				0:       rate = '0;
				1:       rate = 22'd1;
				2:       rate = 22'h3FFFFF;
				3:       rate = 22'($urandom);
				default: rate = 22'($urandom_range(1, 64));
			endcase
			case ($urandom_range(0, 7))
				0:       len = '0;
				1:       len = 17'd65536;
				2:       len = 17'($urandom_range(0, 65536));
				default: len = 17'($urandom_range(1, 40));
			endcase
			case ($urandom_range(0, 7))
				0:       lstart = '0;
				1:       lstart = 16'hFFFF;
				2:       lstart = 16'($urandom);
				default: lstart = 16'($urandom_range(0, 20));
			endcase
			case ($urandom_range(0, 7))
				0:       lend = '0;
				1:       lend = 17'd65536;
				2:       lend = 17'($urandom_range(0, 65536));
				default: lend = 17'($urandom_range(1, 40));
			endcase
			program_player(rate, len, 1'($urandom), lstart, lend,
				$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
			send_item(OP_START, 16'($urandom), 8'($urandom), pick_step());
			n = (phase_no == 3) ? 200 : $urandom_range(40, 110);
			repeat (n) begin
				k = $urandom_range(0, 99);
				if (k < 8)
					send_item(OP_LOAD,
						($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 48)) : 16'($urandom),
						8'($urandom), 15'($urandom_range(0, 32000)));
				else if (k < 12)
					send_item(OP_START, 16'($urandom), 8'($urandom), pick_step());
				else if (k < 15)
					send_item(OP_STOP, 16'($urandom), 8'($urandom),
						15'($urandom_range(0, 32000)));
				else if (k == 15 && !paused) begin
					paused = 1'b1;
					drain();
				end else
					send_tick();
			end
			phase_no++;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ramp();
		test_controls();
		test_loop_wrap();
		test_accum_saturation();
		test_random();
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
